// File: design/xeu_pkg.sv
package xeu_pkg;

   localparam int EntCount  = 14;
   localparam int EntMaxLen = 7;
   localparam int EntDepth  = 6;
   localparam int QDepth    = 2;
   localparam int QPtrW     = $clog2(QDepth);
   localparam int QCntW     = $clog2(QDepth + 1);

   typedef logic [7:0] octet_type;
   typedef logic [2:0] ent_pos_type;
   typedef logic [EntCount-1:0] ent_mask_type;

   localparam octet_type CharAmp   = 8'h26;
   localparam octet_type CharLt    = 8'h3C;
   localparam octet_type CharGt    = 8'h3E;
   localparam octet_type CharQuote = 8'h22;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ESC_ERR = 2'd1,
      STATUS_RAW_ERR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MODE_TEXT   = 3'b001,
      MODE_ENTITY = 3'b010,
      MODE_DROP   = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_ESC_ERR = 2'd1,
      OP_RAW_ERR = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      octet_type   data;
      logic        eos;
   } op_type;

   typedef struct packed {
      logic             full;
      logic             empty;
      logic [QCntW-1:0] count;
   } q_stat_type;

   localparam octet_type ENT_TEXT [EntCount][EntMaxLen] = '{
      '{"q", "u", "o", "t", ";", 8'h00, 8'h00},
      '{"l", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"g", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"a", "m", "p", ";", 8'h00, 8'h00, 8'h00},
      '{"a", "p", "o", "s", ";", 8'h00, 8'h00},
      '{"#", "x", "a", ";", 8'h00, 8'h00, 8'h00},
      '{"#", "x", "A", ";", 8'h00, 8'h00, 8'h00},
      '{"#", "x", "d", ";", 8'h00, 8'h00, 8'h00},
      '{"#", "x", "D", ";", 8'h00, 8'h00, 8'h00},
      '{"#", "x", "2", "0", "1", "8", ";"},
      '{"#", "x", "2", "0", "1", "9", ";"},
      '{"#", "x", "2", "0", "2", "6", ";"},
      '{"#", "x", "2", "0", "1", "c", ";"},
      '{"#", "x", "2", "0", "1", "d", ";"}
   };

   localparam ent_pos_type ENT_LEN [EntCount] = '{
      3'd5, 3'd3, 3'd3, 3'd4, 3'd5, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
   };

   localparam octet_type ENT_VALUE [EntCount] = '{
      8'h22, 8'h3C, 8'h3E, 8'h26, 8'h27, 8'h0A, 8'h0A,
      8'h0D, 8'h0D, 8'h27, 8'h27, 8'h2E, 8'h22, 8'h22
   };

endpackage

// File: design/xml_entity_unescape_decoder_core.sv
// channel  ports                                        direction
// req      req_valid/req_ready, req_in_byte,            in
//          req_end_of_string
// rsp      rsp_valid/rsp_ready, rsp_out_byte,           out
//          rsp_has_byte, rsp_status, rsp_end_of_run
// csr      csr_wr_en, csr_wr_data (allow_quote)         in
//
// One byte per cycle while req_ready holds; each result is queued, then registered.
// The front decoder matches entities against all entries in parallel, one byte a cycle.
// A two-entry queue sits between decoder and output register; req_ready drops when full.
// Synchronous active-high reset; no clearing pass, ready right after reset.
module xml_entity_unescape_decoder_core
   import xeu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_end_of_run,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic       fire, push, pop;
   op_type     push_op, head_op;
   q_stat_type q_stat;

   assign req_ready = !q_stat.full;
   assign fire      = req_valid && req_ready;

   xeu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .in_byte     (req_in_byte),
      .in_eos      (req_end_of_string),
      .push        (push),
      .push_op     (push_op)
   );

   xeu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .stat    (q_stat)
   );

   xeu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_op        (head_op),
      .head_valid     (!q_stat.empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_status     (rsp_status),
      .rsp_end_of_run (rsp_end_of_run)
   );

`ifndef SYNTHESIS
   a_err_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_end_of_run && !rsp_has_byte
         && rsp_out_byte == 8'h00)
      else $error("error result without end of run or with a byte");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCntW'(QDepth) && (q_stat.empty == (q_stat.count == '0)))
      else $error("queue count out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("push into full queue");

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped transaction not presented");
`endif

endmodule

// File: design/xeu_front.sv
module xeu_front
   import xeu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   input  logic      fire,
   input  octet_type in_byte,
   input  logic      in_eos,
   output logic      push,
   output op_type    push_op
);

   mode_type     mode_ff, mode_in;
   ent_pos_type  pos_ff, pos_in;
   ent_mask_type alive_ff, alive_in;
   logic         allow_quote_ff;

   ent_mask_type match, done, cont;
   octet_type    done_value;
   logic         emit;

   always_comb begin
      done_value = '0;
      for (int i = 0; i < EntCount; i++) begin
         match[i] = alive_ff[i] && (ENT_LEN[i] > pos_ff) && (ENT_TEXT[i][pos_ff] == in_byte);
         done[i]  = match[i] && (ENT_LEN[i] == pos_ff + 3'd1);
         cont[i]  = match[i] && !done[i];
         if (done[i]) begin
            done_value = done_value | ENT_VALUE[i];
         end
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      alive_in     = alive_ff;
      emit         = 1'b0;
      push_op.kind = OP_BYTE;
      push_op.data = in_byte;
      push_op.eos  = in_eos;
      case (mode_ff)
         MODE_DROP: begin
            if (in_eos) begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_ENTITY: begin
            if (|done) begin
               emit         = 1'b1;
               push_op.data = done_value;
               mode_in      = MODE_TEXT;
               pos_in       = '0;
            end else if (!(|cont) || pos_ff >= 3'(EntDepth) || in_eos) begin
               emit         = 1'b1;
               push_op.kind = OP_ESC_ERR;
               pos_in       = '0;
               mode_in      = in_eos ? MODE_TEXT : MODE_DROP;
            end else begin
               pos_in   = pos_ff + 3'd1;
               alive_in = cont;
            end
         end
         default: begin
            mode_in = MODE_TEXT;
            if (in_byte == CharAmp) begin
               if (in_eos) begin
                  emit         = 1'b1;
                  push_op.kind = OP_ESC_ERR;
               end else begin
                  mode_in  = MODE_ENTITY;
                  pos_in   = '0;
                  alive_in = '1;
               end
            end else if (in_byte == CharLt || in_byte == CharGt ||
                         (in_byte == CharQuote && !allow_quote_ff)) begin
               emit         = 1'b1;
               push_op.kind = OP_RAW_ERR;
               pos_in       = '0;
               mode_in      = in_eos ? MODE_TEXT : MODE_DROP;
            end else begin
               emit = 1'b1;
            end
         end
      endcase
   end

   assign push = fire && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_TEXT;
         pos_ff         <= '0;
         alive_ff       <= '0;
         allow_quote_ff <= 1'b0;
      end else begin
         if (fire) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            alive_ff <= alive_in;
         end
         if (csr_wr_en) begin
            allow_quote_ff <= csr_wr_data;
         end
      end
   end

endmodule

// File: design/xeu_queue.sv
module xeu_queue
   import xeu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  op_type     push_op,
   input  logic       pop,
   output op_type     head_op,
   output q_stat_type stat
);

   op_type           entries_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] count_ff, count_in;

   assign head_op    = entries_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == QCntW'(QDepth));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// File: design/xeu_back.sv
module xeu_back
   import xeu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  op_type     head_op,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output octet_type  rsp_out_byte,
   output logic       rsp_has_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_end_of_run
);

   logic       valid_ff;
   octet_type  byte_ff, byte_in;
   logic       has_ff, has_in;
   status_type status_ff, status_in;
   logic       eor_ff, eor_in;

   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      byte_in   = '0;
      has_in    = 1'b0;
      eor_in    = 1'b1;
      status_in = STATUS_OK;
      case (head_op.kind)
         OP_BYTE: begin
            byte_in = head_op.data;
            has_in  = 1'b1;
            eor_in  = head_op.eos;
         end
         OP_ESC_ERR: status_in = STATUS_ESC_ERR;
         OP_RAW_ERR: status_in = STATUS_RAW_ERR;
         default:    status_in = STATUS_ESC_ERR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= byte_in;
         has_ff    <= has_in;
         status_ff <= status_in;
         eor_ff    <= eor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_has_byte   = has_ff;
   assign rsp_status     = status_ff;
   assign rsp_end_of_run = eor_ff;

endmodule
